/* rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dive stopwatch and safety stop timer.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int WATCH_W  = 20;
    localparam int AVG_W    = 24;
    localparam int DEPTH_W  = 16;
    localparam int COUNT_W  = 10;
    localparam int MIN_W    = 4;
    localparam int SDEPTH_W = 3;
    localparam int LIMIT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam int NUM_W    = AVG_W + WATCH_W + 1;   // avg*t + d<<8
    localparam int DSR_W    = WATCH_W + 1;           // t+1
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);

    localparam logic [WATCH_W-1:0] WATCH_MAX   = '1;
    localparam logic [DEPTH_W-1:0] TEN_M_CM    = 16'd1000;
    localparam logic [DEPTH_W-1:0] MIN_DIVE_S  = 16'd60;
    localparam logic [DEPTH_W-1:0] CANCEL_3M   = 16'd199;
    localparam logic [DEPTH_W-1:0] CANCEL_DEF  = 16'd299;
    localparam logic [SDEPTH_W-1:0] SDEPTH_3M  = 3'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_3M    = 2'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_DEF   = 2'd3;
    localparam logic [MIN_W-1:0]   RST_STOP_MIN   = 4'd3;
    localparam logic [SDEPTH_W-1:0] RST_STOP_DEPTH = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_MINUTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DEPTH   = 1'd1;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_INIT    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_STOP    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_COMMIT,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic latch;
        logic load_div;
        logic div_step;
        logic commit;
        logic push;
    } dss_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dss_stat_t;

endpackage

/* rtl/dss_ctrl.sv */
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: latches a word, runs the average divider when needed, commits
// the state update and hands the result to the output register.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dss_stat_t stat,
    output dss_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = stat.need_div ? S_MUL : S_COMMIT;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            S_MUL:
            begin
                cmd.load_div = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            S_PUSH:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a word is only taken with no other in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DECIDE))
        else $error("dss_ctrl: accept did not start a word");

    // divider is never skipped once loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_DIV))
        else $error("dss_ctrl: divider load not followed by divide");

    // commit only after the decision or the last divide step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |->
        ($past(state_reg) == S_DECIDE || $past(state_reg) == S_DIV))
        else $error("dss_ctrl: commit from unexpected state");
`endif

endmodule

/* rtl/dss_datapath.sv */
// ----------------------------------------------------------------------------
// dss_datapath
// Stopwatch, running average (multiply then restoring divide, one quotient
// bit per cycle), safety stop counter, config registers and output register.
// ----------------------------------------------------------------------------
module dss_datapath
    import dss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dss_cmd_t              cmd,
    output dss_stat_t             stat,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            mode,
    input  logic [DEPTH_W-1:0]    depth_cm,
    input  logic [DEPTH_W-1:0]    max_depth_cm,
    input  logic [DEPTH_W-1:0]    dive_time_s,
    input  logic                  near_surface,
    input  logic                  ndl_positive,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [WATCH_W-1:0]    watch_seconds,
    output logic [AVG_W-1:0]      avg_depth_q8,
    output logic [COUNT_W-1:0]    countdown_s,
    output logic                  stop_armed,
    output logic [LIMIT_W-1:0]    upper_limit_m
);

    // config
    logic [MIN_W-1:0]    stop_min_reg;
    logic [SDEPTH_W-1:0] stop_depth_reg;

    // latched word
    mode_t              mode_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] maxd_reg;
    logic [DEPTH_W-1:0] dtime_reg;
    logic               near_reg;
    logic               ndl_reg;

    // architectural state
    logic [WATCH_W-1:0] watch_reg,   watch_next;
    logic [AVG_W-1:0]   avg_reg,     avg_next;
    logic               running_reg, running_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               armed_reg,   armed_next;
    logic [DEPTH_W-1:0] prev_reg,    prev_next;

    // divider
    logic [NUM_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [AVG_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // output register
    logic               rsp_valid_reg;
    logic [WATCH_W-1:0] o_watch_reg;
    logic [AVG_W-1:0]   o_avg_reg;
    logic [COUNT_W-1:0] o_count_reg;
    logic               o_armed_reg;
    logic [LIMIT_W-1:0] o_limit_reg;

    logic [2*AVG_W-1:0] prod;
    logic [NUM_W-1:0]   num;
    logic [DSR_W:0]     rem_sh;
    logic               rem_ge;
    logic [DSR_W:0]     rem_sub;
    logic [AVG_W-1:0]   depth_q8;

    logic               ss_en;
    logic               arm_now;
    logic [COUNT_W-1:0] stop_cm;
    logic [COUNT_W-1:0] load_val;
    logic [COUNT_W-1:0] cnt_upd;
    logic [DEPTH_W-1:0] cancel_cm;
    logic               ss_clear;
    logic               watch_adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_min_reg   <= RST_STOP_MIN;
            stop_depth_reg <= RST_STOP_DEPTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STOP_MINUTES: stop_min_reg   <= cfg_data;
                REG_STOP_DEPTH:   stop_depth_reg <= cfg_data[SDEPTH_W-1:0];
                default:          stop_min_reg   <= stop_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= mode_t'(mode);
            depth_reg <= depth_cm;
            maxd_reg  <= max_depth_cm;
            dtime_reg <= dive_time_s;
            near_reg  <= near_surface;
            ndl_reg   <= ndl_positive;
        end
    end

    assign depth_q8 = {depth_reg, 8'd0};

    // avg*t + d<<8, registered into the divider
    assign prod   = {{AVG_W{1'b0}}, avg_reg} * {{(2*AVG_W-WATCH_W){1'b0}}, watch_reg};
    assign num    = NUM_W'(prod[AVG_W+WATCH_W-1:0]) + NUM_W'(depth_q8);

    assign rem_sh  = {rem_reg, dvd_reg[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            dvd_reg  <= num;
            rem_reg  <= '0;
            dsr_reg  <= {1'b0, watch_reg} + DSR_W'(1);
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            quo_reg  <= {quo_reg[AVG_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    assign stat.need_div = (mode_reg == MODE_TICK) && running_reg && !near_reg
                           && (watch_reg != '0);
    assign stat.div_last = dcnt_reg == DCNT_W'(DIV_STEPS - 1);
    assign stat.out_free = !rsp_valid_reg || rsp_ready;

    // safety stop
    assign ss_en    = (stop_min_reg != '0) && (maxd_reg > TEN_M_CM)
                      && (dtime_reg > MIN_DIVE_S);
    assign arm_now  = armed_reg || ((prev_reg > TEN_M_CM) && (depth_reg <= TEN_M_CM)
                      && ndl_reg);
    assign stop_cm  = {{(COUNT_W-SDEPTH_W){1'b0}}, stop_depth_reg} * COUNT_W'(100);
    assign load_val = {{(COUNT_W-MIN_W){1'b0}}, stop_min_reg} * COUNT_W'(60);
    assign cancel_cm = (stop_depth_reg == SDEPTH_3M) ? CANCEL_3M : CANCEL_DEF;

    always_comb
    begin
        cnt_upd = count_reg;
        if (arm_now && (depth_reg <= DEPTH_W'(stop_cm)))
        begin
            cnt_upd = (count_reg == '0) ? load_val : count_reg - COUNT_W'(1);
        end
    end

    assign ss_clear  = (cnt_upd == COUNT_W'(1)) || (depth_reg <= cancel_cm);
    assign watch_adv = running_reg && !near_reg;

    always_comb
    begin
        watch_next   = watch_reg;
        avg_next     = avg_reg;
        running_next = running_reg;
        count_next   = count_reg;
        armed_next   = armed_reg;
        prev_next    = prev_reg;
        if (cmd.commit)
        begin
            case (mode_reg)
                MODE_TICK:
                begin
                    if (watch_adv)
                    begin
                        avg_next = (watch_reg == '0) ? depth_q8 : quo_reg;
                        if (watch_reg != WATCH_MAX)
                        begin
                            watch_next = watch_reg + WATCH_W'(1);
                        end
                    end
                    if (ss_en && !ss_clear)
                    begin
                        armed_next = arm_now;
                        count_next = cnt_upd;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        count_next = '0;
                    end
                    prev_next = depth_reg;
                end
                MODE_INIT:
                begin
                    watch_next   = '0;
                    avg_next     = '0;
                    running_next = 1'b1;
                    count_next   = '0;
                end
                MODE_RESTART:
                begin
                    watch_next   = '0;
                    avg_next     = depth_q8;
                    running_next = 1'b1;
                end
                MODE_STOP:
                begin
                    running_next = 1'b0;
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_reg   <= '0;
            avg_reg     <= '0;
            running_reg <= 1'b0;
            count_reg   <= '0;
            armed_reg   <= 1'b0;
            prev_reg    <= '0;
        end
        else
        begin
            watch_reg   <= watch_next;
            avg_reg     <= avg_next;
            running_reg <= running_next;
            count_reg   <= count_next;
            armed_reg   <= armed_next;
            prev_reg    <= prev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            o_watch_reg <= watch_reg;
            o_avg_reg   <= avg_reg;
            o_count_reg <= count_reg;
            o_armed_reg <= armed_reg;
            o_limit_reg <= (stop_depth_reg == SDEPTH_3M) ? LIMIT_3M : LIMIT_DEF;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign watch_seconds = o_watch_reg;
    assign avg_depth_q8  = o_avg_reg;
    assign countdown_s   = o_count_reg;
    assign stop_armed    = o_armed_reg;
    assign upper_limit_m = o_limit_reg;

`ifndef SYNTHESIS
    // a running countdown implies an armed stop
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> armed_reg)
        else $error("dss_datapath: countdown without armed stop");

    // countdown never exceeds fifteen minutes
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(900))
        else $error("dss_datapath: countdown out of range");

    // stopwatch only halts on a stop command
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> $past(cmd.commit && (mode_reg == MODE_STOP)))
        else $error("dss_datapath: stopwatch halted without stop command");
`endif

endmodule

/* rtl/dive_stopwatch_safety_stop_timer_top.sv */
// ----------------------------------------------------------------------------
// dive_stopwatch_safety_stop_timer_top
// Dive stopwatch with running average depth and safety stop countdown.
// ----------------------------------------------------------------------------
// One word per second tick or command; every word gives one result word with
// the state after it. A tick that advances a stopwatch already past its first
// second runs the divider: the running average is avg*t + d<<8 formed in a
// multiply state, then divided by t+1 in a restoring divider producing one bit
// per cycle. Every other word goes straight from the decision to the commit.
// The input side is ready again once the result is in the output register,
// while it may still wait to be read. Config writes are taken at any time and
// should be made while idle.
module dive_stopwatch_safety_stop_timer_top
    import dss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [1:0]            mode,
    input  logic [DEPTH_W-1:0]    depth_cm,
    input  logic [DEPTH_W-1:0]    max_depth_cm,
    input  logic [DEPTH_W-1:0]    dive_time_s,
    input  logic                  near_surface,
    input  logic                  ndl_positive,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [WATCH_W-1:0]    watch_seconds,
    output logic [AVG_W-1:0]      avg_depth_q8,
    output logic [COUNT_W-1:0]    countdown_s,
    output logic                  stop_armed,
    output logic [LIMIT_W-1:0]    upper_limit_m
);

    dss_cmd_t  cmd;
    dss_stat_t stat;

    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dss_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .depth_cm      (depth_cm),
        .max_depth_cm  (max_depth_cm),
        .dive_time_s   (dive_time_s),
        .near_surface  (near_surface),
        .ndl_positive  (ndl_positive),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .watch_seconds (watch_seconds),
        .avg_depth_q8  (avg_depth_q8),
        .countdown_s   (countdown_s),
        .stop_armed    (stop_armed),
        .upper_limit_m (upper_limit_m)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dive stopwatch and safety stop timer. A
// scoreboard keeps its own copy of the stopwatch, average depth and safety
// stop state and predicts the status word for every accepted request word.
// A short directed run at reset settings is followed by phases of random
// dive profiles under a range of stop durations and depths, with bursty
// requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_top;
    import dss_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 195;
    localparam int END_CYCLES  = 60;

    typedef struct packed {
        mode_t              mode;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] max_depth;
        logic [DEPTH_W-1:0] dive_time;
        logic               near_surface;
        logic               ndl_positive;
    } request_t;

    typedef struct packed {
        logic [WATCH_W-1:0] watch_seconds;
        logic [AVG_W-1:0]   avg_depth_q8;
        logic [COUNT_W-1:0] countdown_s;
        logic               stop_armed;
        logic [LIMIT_W-1:0] upper_limit_m;
    } status_t;

    class timer_scoreboard;
        logic [MIN_W-1:0]    stop_minutes;
        logic [SDEPTH_W-1:0] stop_depth;
        logic [WATCH_W-1:0]  watch_count;
        logic [AVG_W-1:0]    avg_q8;
        logic                running;
        logic [COUNT_W-1:0]  stop_count;
        logic                armed;
        logic [DEPTH_W-1:0]  prev_depth;
        status_t             pending_status[$];
        int                  failures;

        function new();
            stop_minutes = RST_STOP_MIN;
            stop_depth   = RST_STOP_DEPTH;
            watch_count  = '0;
            avg_q8       = '0;
            running      = 1'b0;
            stop_count   = '0;
            armed        = 1'b0;
            prev_depth   = '0;
            failures     = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_STOP_MINUTES)
                stop_minutes = data;
            else
                stop_depth = data[SDEPTH_W-1:0];
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        function void note_request(input request_t rq);
            status_t            st;
            logic [63:0]        wide_t;
            logic [63:0]        num;
            logic [DEPTH_W-1:0] cancel_cm;
            case (rq.mode)
                MODE_TICK: begin
                    if (running && !rq.near_surface) begin
                        if (watch_count == '0)
                            avg_q8 = {rq.depth, 8'h00};
                        else begin
                            wide_t = 64'(watch_count);
                            num = wide_t * 64'(avg_q8) + 64'({rq.depth, 8'h00});
                            avg_q8 = AVG_W'(num / (wide_t + 64'd1));
                        end
                        if (watch_count != WATCH_MAX)
                            watch_count = watch_count + 1'b1;
                    end
                    if (stop_minutes != '0 && rq.max_depth > TEN_M_CM
                            && rq.dive_time > MIN_DIVE_S) begin
                        if (prev_depth > TEN_M_CM && rq.depth <= TEN_M_CM && rq.ndl_positive)
                            armed = 1'b1;
                        if (armed && rq.depth <= stop_depth * 16'd100) begin
                            if (stop_count == '0)
                                stop_count = stop_minutes * 10'd60;
                            else
                                stop_count = stop_count - 1'b1;
                        end
                        cancel_cm = (stop_depth == SDEPTH_3M) ? CANCEL_3M : CANCEL_DEF;
                        if (stop_count == 10'd1 || rq.depth <= cancel_cm) begin
                            armed      = 1'b0;
                            stop_count = '0;
                        end
                    end
                    else begin
                        armed      = 1'b0;
                        stop_count = '0;
                    end
                    prev_depth = rq.depth;
                end
                MODE_INIT: begin
                    watch_count = '0;
                    avg_q8      = '0;
                    running     = 1'b1;
                    stop_count  = '0;
                end
                MODE_RESTART: begin
                    watch_count = '0;
                    avg_q8      = {rq.depth, 8'h00};
                    running     = 1'b1;
                end
                default: begin
                    running = 1'b0;
                end
            endcase
            st.watch_seconds = watch_count;
            st.avg_depth_q8  = avg_q8;
            st.countdown_s   = stop_count;
            st.stop_armed    = armed;
            st.upper_limit_m = (stop_depth == SDEPTH_3M) ? LIMIT_3M : LIMIT_DEF;
            pending_status.push_back(st);
        endfunction

        function void check_status(input status_t got);
            status_t want;
            if (pending_status.size() == 0) begin
                $error("status word with nothing expected");
                failures++;
                return;
            end
            want = pending_status.pop_front();
            if (got.watch_seconds != want.watch_seconds) begin
                $error("watch_seconds: expected %0d, actual %0d",
                       want.watch_seconds, got.watch_seconds);
                failures++;
            end
            if (got.avg_depth_q8 != want.avg_depth_q8) begin
                $error("avg_depth_q8: expected %0d, actual %0d",
                       want.avg_depth_q8, got.avg_depth_q8);
                failures++;
            end
            if (got.countdown_s != want.countdown_s) begin
                $error("countdown_s: expected %0d, actual %0d",
                       want.countdown_s, got.countdown_s);
                failures++;
            end
            if (got.stop_armed != want.stop_armed) begin
                $error("stop_armed: expected %0d, actual %0d",
                       want.stop_armed, got.stop_armed);
                failures++;
            end
            if (got.upper_limit_m != want.upper_limit_m) begin
                $error("upper_limit_m: expected %0d, actual %0d",
                       want.upper_limit_m, got.upper_limit_m);
                failures++;
            end
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  req_valid    = 1'b0;
    logic                  req_ready;
    logic [1:0]            mode         = '0;
    logic [DEPTH_W-1:0]    depth_cm     = '0;
    logic [DEPTH_W-1:0]    max_depth_cm = '0;
    logic [DEPTH_W-1:0]    dive_time_s  = '0;
    logic                  near_surface = 1'b0;
    logic                  ndl_positive = 1'b0;
    logic                  rsp_valid;
    logic                  rsp_ready    = 1'b0;
    logic [WATCH_W-1:0]    watch_seconds;
    logic [AVG_W-1:0]      avg_depth_q8;
    logic [COUNT_W-1:0]    countdown_s;
    logic                  stop_armed;
    logic [LIMIT_W-1:0]    upper_limit_m;

    timer_scoreboard sb;
    int              burst_left  = 0;
    int              ready_left  = 0;
    int              cycle_count = 0;

    logic [3:0] phase_minutes [NUM_PHASES] = '{4'd0, 4'd15, 4'd1, 4'd1, 4'd2,
                                               4'd15, 4'd1, 4'd2, 4'd1, 4'd1};
    logic [3:0] phase_depth   [NUM_PHASES] = '{4'd3, 4'd6, 4'd3, 4'd7, 4'd0,
                                               4'd3, 4'd5, 4'd6, 4'd4, 4'd4};

    dive_stopwatch_safety_stop_timer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .mode         (mode),
        .depth_cm     (depth_cm),
        .max_depth_cm (max_depth_cm),
        .dive_time_s  (dive_time_s),
        .near_surface (near_surface),
        .ndl_positive (ndl_positive),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .watch_seconds(watch_seconds),
        .avg_depth_q8 (avg_depth_q8),
        .countdown_s  (countdown_s),
        .stop_armed   (stop_armed),
        .upper_limit_m(upper_limit_m)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: ready runs with short stalls, now and then a long open run
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            if (rsp_ready)
            begin
                rsp_ready  <= 1'b0;
                ready_left <= $urandom_range(1, 6);
            end
            else
            begin
                rsp_ready  <= 1'b1;
                ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(1, 20);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    always @(posedge clk)
    begin : status_monitor
        status_t seen;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            seen.watch_seconds = watch_seconds;
            seen.avg_depth_q8  = avg_depth_q8;
            seen.countdown_s   = countdown_s;
            seen.stop_armed    = stop_armed;
            seen.upper_limit_m = upper_limit_m;
            sb.check_status(seen);
        end
    end

    function automatic request_t make_word(input mode_t m, input int depth, input int maxd,
                                           input int dtime, input logic ns, input logic ndl);
        request_t rq;
        rq.mode         = m;
        rq.depth        = DEPTH_W'(depth);
        rq.max_depth    = DEPTH_W'(maxd);
        rq.dive_time    = DEPTH_W'(dtime);
        rq.near_surface = ns;
        rq.ndl_positive = ndl;
        return rq;
    endfunction

    function automatic request_t random_word();
        return make_word(mode_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_word(input request_t rq);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 12);
        end
        req_valid    <= 1'b1;
        mode         <= rq.mode;
        depth_cm     <= rq.depth;
        max_depth_cm <= rq.max_depth;
        dive_time_s  <= rq.dive_time;
        near_surface <= rq.near_surface;
        ndl_positive <= rq.ndl_positive;
        do @(posedge clk); while (!req_ready);
        sb.note_request(rq);
        burst_left--;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] minutes,
                              input logic [CFG_DATA_W-1:0] depth_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_STOP_MINUTES;
        cfg_data  <= minutes;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(REG_STOP_MINUTES, minutes);
        cfg_index <= REG_STOP_DEPTH;
        cfg_data  <= depth_data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(REG_STOP_DEPTH, depth_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic dive_tick(input int depth, input logic [DEPTH_W-1:0] maxd,
                             inout logic [DEPTH_W-1:0] dtime, input logic ns,
                             input logic ndl, inout int left);
        request_t rq;
        if ($urandom_range(0, 24) == 0)
            rq = random_word();
        else
            rq = make_word(MODE_TICK, depth, maxd, dtime,
                           ns ^ ($urandom_range(0, 19) == 0), ndl);
        send_word(rq);
        if (dtime != 16'hFFFF)
            dtime++;
        left--;
    endtask

    // descent past 10 m, ascent to the stop, a stay there, then the surface
    task automatic run_dive(inout int left);
        logic [DEPTH_W-1:0] maxd;
        logic [DEPTH_W-1:0] dtime;
        logic               ndl;
        int                 lo;
        int                 hi;
        int                 n;
        lo = (sb.stop_depth == SDEPTH_3M) ? 200 : 300;
        hi = sb.stop_depth * 100;
        if (hi < lo)
            hi = lo + 150;
        maxd  = DEPTH_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1000)
                                                     : $urandom_range(1001, 65535));
        dtime = DEPTH_W'(($urandom_range(0, 5) == 0) ? $urandom_range(40, 70)
                                                     : $urandom_range(61, 65000));
        send_word(make_word(($urandom_range(0, 3) == 0) ? MODE_INIT : MODE_RESTART,
                            $urandom_range(0, 4000), maxd, dtime, 1'b0, 1'b1));
        left--;
        n = $urandom_range(2, 8);
        for (int i = 0; i < n && left > 0; i++)
            dive_tick($urandom_range(1001, 8000), maxd, dtime, 1'b0, 1'b1, left);
        ndl = ($urandom_range(0, 7) != 0);
        if (left > 0)
            dive_tick($urandom_range(lo, 1000), maxd, dtime, 1'b0, ndl, left);
        n = sb.stop_minutes * 60 + $urandom_range(0, 10) - 5;
        if (n < 3)
            n = 3;
        for (int i = 0; i < n && left > 0; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                dive_tick($urandom_range(1001, 1200), maxd, dtime, 1'b0, 1'b1, left);
            else if ($urandom_range(0, 59) == 0)
                dive_tick($urandom_range(0, lo - 1), maxd, dtime, 1'b0, 1'b1, left);
            else
                dive_tick($urandom_range(lo, hi), maxd, dtime, 1'b0, 1'b1, left);
        end
        n = $urandom_range(2, 6);
        for (int i = 0; i < n && left > 0; i++)
            dive_tick($urandom_range(0, 150), maxd, dtime, 1'b1, 1'b1, left);
        if (left > 0 && $urandom_range(0, 1) == 0)
        begin
            send_word(make_word(MODE_STOP, $urandom_range(0, 65535), maxd, dtime, 1'b1, 1'b0));
            left--;
        end
    endtask

    task automatic directed_words();
        send_word(make_word(MODE_TICK, 3000, 65535, 65535, 1'b0, 1'b1));
        send_word(make_word(MODE_INIT, 0, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_TICK, 65535, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_TICK, 65535, 0, 0, 1'b1, 1'b0));
        send_word(make_word(MODE_TICK, 777, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_RESTART, 12345, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_TICK, 12000, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_STOP, 65535, 65535, 65535, 1'b1, 1'b1));
        send_word(make_word(MODE_TICK, 500, 0, 0, 1'b0, 1'b0));
        send_word(make_word(MODE_RESTART, 0, 0, 0, 1'b0, 1'b0));
        // safety stop at reset settings
        send_word(make_word(MODE_TICK, 2000, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 1000, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 501, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 500, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 450, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_INIT, 450, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 400, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 300, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 299, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 1500, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 900, 1001, 61, 1'b0, 1'b0));
        send_word(make_word(MODE_TICK, 1500, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 900, 1001, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 400, 1000, 61, 1'b0, 1'b1));
        send_word(make_word(MODE_TICK, 1500, 65535, 60, 1'b0, 1'b1));
    endtask

    initial
    begin
        int                    left;
        logic [CFG_DATA_W-1:0] minutes;
        logic [CFG_DATA_W-1:0] depth_data;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_words();
        drain();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            minutes    = (p == 8) ? CFG_DATA_W'($urandom_range(0, 15)) : phase_minutes[p];
            depth_data = (p == 8) ? CFG_DATA_W'($urandom_range(0, 15))
                                  : (phase_depth[p] | CFG_DATA_W'($urandom_range(0, 1) << 3));
            set_config(minutes, depth_data);
            left = PHASE_WORDS;
            while (left > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(random_word());
                    left--;
                end
                else
                    run_dive(left);
            end
            drain();
        end
        repeat (END_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
